// ----- rtl/i2cpm_pkg.sv -----
// Package for the paged I2C target memory map.
// Holds the opcode, bank and controller state codes and the command/status structs.
// No dependencies.
`default_nettype none

package i2cpm_pkg;

  localparam int unsigned PageBytes = 128;

  localparam logic [7:0] SelZero     = 8'h00;
  localparam logic [7:0] SelSeventyF = 8'h7F;

  typedef enum logic [1:0] {
    OP_ADDR_WR = 2'd0,
    OP_ADDR_RD = 2'd1,
    OP_BYTE_RX = 2'd2,
    OP_BYTE_TX = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    BANK_LOWER     = 2'd0,
    BANK_ZERO      = 2'd1,
    BANK_SEVENTY_F = 2'd2
  } bank_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic needs_read;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/i2cpm_if.sv -----
// Handshake channels of the paged I2C target memory map.
// Depends on nothing; carries valid, ready and the item payload.
`default_nettype none

interface i2cpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface i2cpm_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_data;

  modport source (output valid, output tx_valid, output tx_data, input ready);
  modport sink   (input valid, input tx_valid, input tx_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/i2cpm_dp.sv -----
// Datapath: item register, pointer/bank state, three page memories with clearing pass.
// Depends on i2cpm_pkg; driven by commands from i2cpm_ctrl.
`default_nettype none

module i2cpm_dp #(
  parameter int unsigned PAGE_BYTES = i2cpm_pkg::PageBytes
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire i2cpm_pkg::dp_cmd_t    cmd_i,
  output i2cpm_pkg::dp_status_t      status_o,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [7:0]            data_byte_i,
  output logic [7:0]                 tx_data_o
);

  localparam int unsigned IdxW  = $clog2(PAGE_BYTES);
  localparam int unsigned AddrW = IdxW + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PAGE_BYTES - 1);

  logic [7:0] lower_mem [PAGE_BYTES];
  logic [7:0] zero_mem  [PAGE_BYTES];
  logic [7:0] sevf_mem  [PAGE_BYTES];

  i2cpm_pkg::opcode_e op_q;
  logic [7:0]         byte_q;

  logic [AddrW-1:0]   addr_q, addr_d;
  i2cpm_pkg::bank_e   bank_q, bank_d;
  logic               expect_q, expect_d;
  logic [7:0]         sel_q, sel_d;

  logic [IdxW-1:0]    clr_idx_q;
  logic               clr_busy_q;

  logic               wr_en;
  logic [7:0]         sel_w;
  logic [AddrW-1:0]   new_addr;

  logic [7:0]         rdata_q;
  logic               rd_sel_q;
  logic [7:0]         tx_data_q;

  assign status_o.busy       = clr_busy_q;
  assign status_o.needs_read = (op_q == i2cpm_pkg::OP_ADDR_RD) ||
                               (op_q == i2cpm_pkg::OP_BYTE_TX);
  assign tx_data_o           = tx_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= i2cpm_pkg::opcode_e'(opcode_i);
      byte_q <= data_byte_i;
    end
  end

  always_comb begin
    addr_d   = addr_q;
    bank_d   = bank_q;
    expect_d = expect_q;
    sel_d    = sel_q;
    wr_en    = 1'b0;
    sel_w    = sel_q;
    new_addr = byte_q[AddrW-1:0];
    case (op_q)
      i2cpm_pkg::OP_ADDR_WR,
      i2cpm_pkg::OP_ADDR_RD: begin
        expect_d = 1'b1;
      end
      i2cpm_pkg::OP_BYTE_RX: begin
        if (expect_q) begin
          expect_d = 1'b0;
          addr_d   = new_addr;
          if (new_addr[AddrW-1]) begin
            if (sel_q == i2cpm_pkg::SelSeventyF) begin
              bank_d = i2cpm_pkg::BANK_SEVENTY_F;
            end else begin
              bank_d = i2cpm_pkg::BANK_ZERO;
              sel_d  = i2cpm_pkg::SelZero;
            end
          end else begin
            bank_d = i2cpm_pkg::BANK_LOWER;
          end
        end else begin
          wr_en = 1'b1;
          if (bank_q == i2cpm_pkg::BANK_LOWER && addr_q[IdxW-1:0] == LastIdx) begin
            sel_w = byte_q;
            sel_d = byte_q;
          end
        end
      end
      default: begin
      end
    endcase
    if (op_q == i2cpm_pkg::OP_BYTE_TX ||
        (op_q == i2cpm_pkg::OP_BYTE_RX && !expect_q)) begin
      addr_d = addr_q + AddrW'(1);
      if (addr_q == {1'b0, LastIdx}) begin
        if (sel_w == i2cpm_pkg::SelSeventyF) begin
          bank_d = i2cpm_pkg::BANK_SEVENTY_F;
        end else begin
          bank_d = i2cpm_pkg::BANK_ZERO;
          sel_d  = i2cpm_pkg::SelZero;
        end
      end else if (&addr_q) begin
        bank_d = i2cpm_pkg::BANK_LOWER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      bank_q     <= i2cpm_pkg::BANK_LOWER;
      expect_q   <= 1'b1;
      sel_q      <= i2cpm_pkg::SelZero;
      clr_idx_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + IdxW'(1);
        if (clr_idx_q == LastIdx) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (cmd_i.exec) begin
        addr_q   <= addr_d;
        bank_q   <= bank_d;
        expect_q <= expect_d;
        sel_q    <= sel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      lower_mem[clr_idx_q] <= '0;
      zero_mem[clr_idx_q]  <= '0;
      sevf_mem[clr_idx_q]  <= '0;
    end else if (cmd_i.exec && wr_en) begin
      case (bank_q)
        i2cpm_pkg::BANK_LOWER:     lower_mem[addr_q[IdxW-1:0]] <= byte_q;
        i2cpm_pkg::BANK_SEVENTY_F: sevf_mem[addr_q[IdxW-1:0]]  <= byte_q;
        default:                   zero_mem[addr_q[IdxW-1:0]]  <= byte_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_sel_q <= (bank_q == i2cpm_pkg::BANK_LOWER) && (addr_q[IdxW-1:0] == LastIdx);
      case (bank_q)
        i2cpm_pkg::BANK_LOWER:     rdata_q <= lower_mem[addr_q[IdxW-1:0]];
        i2cpm_pkg::BANK_SEVENTY_F: rdata_q <= sevf_mem[addr_q[IdxW-1:0]];
        default:                   rdata_q <= zero_mem[addr_q[IdxW-1:0]];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tx_data_q <= rd_sel_q ? sel_q : rdata_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/i2cpm_ctrl.sv -----
// Controller: sequences capture, update, memory read and output load per item.
// Depends on i2cpm_pkg; drives i2cpm_dp through command/status structs.
`default_nettype none

module i2cpm_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output i2cpm_pkg::dp_cmd_t         cmd_o,
  input  wire i2cpm_pkg::dp_status_t status_i
);

  i2cpm_pkg::ctrl_state_e state_q, state_d;
  logic                   out_valid_q, out_valid_d;

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i2cpm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      i2cpm_pkg::ST_IDLE: begin
        in_ready_o = !status_i.busy;
        if (in_valid_i && !status_i.busy) begin
          cmd_o.capture = 1'b1;
          state_d       = i2cpm_pkg::ST_EXEC;
        end
      end
      i2cpm_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.needs_read ? i2cpm_pkg::ST_READ : i2cpm_pkg::ST_IDLE;
      end
      i2cpm_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = i2cpm_pkg::ST_LOAD;
      end
      i2cpm_pkg::ST_LOAD: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = i2cpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = i2cpm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/i2c_target_paged_memory_map.sv -----
// Paged I2C target memory map: 128-byte lower page plus two selectable upper pages.
// Top level; depends on i2cpm_pkg, i2cpm_if, i2cpm_ctrl and i2cpm_dp.
//
// in_i carries one bus event per item: opcode (address match write/read, byte
// received, byte transmitted) and data_byte. out_o returns one item with
// tx_valid = 1 and tx_data for each address match read and byte transmitted event;
// the other two events produce no output item.
// An item without a response passes through accept and state update. An item with a
// response passes through accept, state update, page memory read and output load;
// its output item is valid once the output load step has run. The page memories are
// read after the pointer update, so a read sees the updated pointer.
// After reset the pointer is lower address 0 and the next byte received is an
// address byte. A clearing pass then zeroes all three pages, one row per cycle;
// in_i.ready stays low until it ends.
// The output register holds an item until taken; the next input item is accepted
// meanwhile, and a further response waits in its load step while out_o stalls.
`default_nettype none

module i2c_target_paged_memory_map #(
  parameter int unsigned PAGE_BYTES = i2cpm_pkg::PageBytes
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  i2cpm_in_if.sink     in_i,
  i2cpm_out_if.source  out_o
);

  i2cpm_pkg::dp_cmd_t    cmd;
  i2cpm_pkg::dp_status_t status;
  logic                  in_ready;
  logic                  out_valid;
  logic [7:0]            tx_data;

  assign in_i.ready     = in_ready;
  assign out_o.valid    = out_valid;
  assign out_o.tx_valid = 1'b1;
  assign out_o.tx_data  = tx_data;

  i2cpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  i2cpm_dp #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .opcode_i    (in_i.opcode),
    .data_byte_i (in_i.data_byte),
    .tx_data_o   (tx_data)
  );

endmodule

`default_nettype wire

// ----- dv/i2c_target_paged_memory_map_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the paged I2C target memory map.
// Holds its own model of the paged memory and checks every read-back byte.
// Depends on i2cpm_pkg, i2cpm_if and the i2c_target_paged_memory_map RTL.

module i2c_target_paged_memory_map_tb;

  localparam logic [7:0] SelectAddr = 8'h7F;
  localparam logic [7:0] TopAddr    = 8'hFF;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned RandomItems = 850;
  localparam int unsigned NumPhases = 4;

  typedef struct packed {
    i2cpm_pkg::opcode_e op;
    logic [7:0]         data;
  } bus_event_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_data;
  } tx_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  i2cpm_in_if  in_if ();
  i2cpm_out_if out_if ();

  i2c_target_paged_memory_map uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic               drv_valid = 1'b0;
  i2cpm_pkg::opcode_e drv_op = i2cpm_pkg::OP_ADDR_WR;
  logic [7:0]         drv_byte = 8'h00;
  logic               take_ready = 1'b0;

  assign in_if.valid     = drv_valid;
  assign in_if.opcode    = drv_op;
  assign in_if.data_byte = drv_byte;
  assign out_if.ready    = take_ready;

  bus_event_t  pending_events[$];
  tx_byte_t    tx_expected[$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned queued_total = 0;
  int unsigned events_accepted = 0;
  int unsigned bytes_checked = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // memory model: index 0 lower page, 1 upper page zero, 2 upper page seventy_f
  logic [7:0]         page_mem [0:2][0:i2cpm_pkg::PageBytes-1];
  logic [7:0]         cur_addr;
  i2cpm_pkg::bank_e   cur_bank;
  logic               want_addr_byte;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void select_upper();
    if (page_mem[i2cpm_pkg::BANK_LOWER][SelectAddr[6:0]] == i2cpm_pkg::SelSeventyF) begin
      cur_bank = i2cpm_pkg::BANK_SEVENTY_F;
    end else begin
      if (page_mem[i2cpm_pkg::BANK_LOWER][SelectAddr[6:0]] != i2cpm_pkg::SelZero) begin
        page_mem[i2cpm_pkg::BANK_LOWER][SelectAddr[6:0]] = i2cpm_pkg::SelZero;
      end
      cur_bank = i2cpm_pkg::BANK_ZERO;
    end
  endfunction

  function automatic void step_pointer();
    logic [7:0] prev;
    prev = cur_addr;
    cur_addr = prev + 8'd1;
    if (prev == SelectAddr) begin
      select_upper();
    end else if (prev == TopAddr) begin
      cur_bank = i2cpm_pkg::BANK_LOWER;
    end
  endfunction

  function automatic void apply_event(bus_event_t ev);
    tx_byte_t rsp;
    rsp.tx_valid = 1'b1;
    case (ev.op)
      i2cpm_pkg::OP_ADDR_WR: begin
        want_addr_byte = 1'b1;
      end
      i2cpm_pkg::OP_ADDR_RD: begin
        want_addr_byte = 1'b1;
        rsp.tx_data = page_mem[cur_bank][cur_addr[6:0]];
        tx_expected.push_back(rsp);
      end
      i2cpm_pkg::OP_BYTE_RX: begin
        if (want_addr_byte) begin
          want_addr_byte = 1'b0;
          cur_addr = ev.data;
          if (ev.data[7]) begin
            select_upper();
          end else begin
            cur_bank = i2cpm_pkg::BANK_LOWER;
          end
        end else begin
          page_mem[cur_bank][cur_addr[6:0]] = ev.data;
          step_pointer();
        end
      end
      default: begin
        step_pointer();
        rsp.tx_data = page_mem[cur_bank][cur_addr[6:0]];
        tx_expected.push_back(rsp);
      end
    endcase
  endfunction

  function automatic void flag_mismatch(string what, logic [8:0] want, logic [8:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH %s: expected %0h, got %0h (byte %0d)", what, want, got,
               bytes_checked);
    end
  endfunction

  // driver: offer the next pending item, hold it until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_if.ready) begin
      if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_valid <= 1'b1;
        drv_op    <= pending_events[0].op;
        drv_byte  <= pending_events[0].data;
        void'(pending_events.pop_front());
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_ready <= 1'b0;
    end else begin
      take_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: predict on accepted items, check returned bytes, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        apply_event('{op: i2cpm_pkg::opcode_e'(in_if.opcode), data: in_if.data_byte});
        events_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        if (tx_expected.size() == 0) begin
          flag_mismatch("unexpected tx item", 9'h0, {out_if.tx_valid, out_if.tx_data});
        end else begin
          if (out_if.tx_valid !== tx_expected[0].tx_valid) begin
            flag_mismatch("tx_valid", 9'(tx_expected[0].tx_valid), 9'(out_if.tx_valid));
          end
          if (out_if.tx_data !== tx_expected[0].tx_data) begin
            flag_mismatch("tx_data", 9'(tx_expected[0].tx_data), 9'(out_if.tx_data));
          end
          void'(tx_expected.pop_front());
          bytes_checked++;
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("TIMEOUT: no item moved for %0d cycles", StallLimit);
        $display("i2c_target_paged_memory_map verification failed");
        $finish;
      end
    end
  end

  task automatic push_event(i2cpm_pkg::opcode_e op, logic [7:0] data);
    pending_events.push_back('{op: op, data: data});
    queued_total++;
  endtask

  function automatic logic [7:0] pick_addr();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return SelectAddr;
    if (roll < 40) return 8'($urandom_range(8'h70, 8'h7F));
    if (roll < 65) return 8'($urandom_range(8'hF0, 8'hFF));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_data();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 25) return i2cpm_pkg::SelSeventyF;
    if (roll < 40) return i2cpm_pkg::SelZero;
    if (roll < 50) return TopAddr;
    return 8'($urandom);
  endfunction

  task automatic queue_random(int unsigned count);
    int unsigned start;
    int unsigned kind;
    int unsigned len;
    start = queued_total;
    while (queued_total - start < count) begin
      kind = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(6, 1);
      if (kind < 40) begin
        push_event(i2cpm_pkg::OP_ADDR_WR, 8'($urandom));
        push_event(i2cpm_pkg::OP_BYTE_RX, pick_addr());
        repeat (len) push_event(i2cpm_pkg::OP_BYTE_RX, pick_data());
      end else if (kind < 80) begin
        push_event(i2cpm_pkg::OP_ADDR_WR, 8'($urandom));
        push_event(i2cpm_pkg::OP_BYTE_RX, pick_addr());
        push_event(i2cpm_pkg::OP_ADDR_RD, 8'($urandom));
        repeat (len) push_event(i2cpm_pkg::OP_BYTE_TX, 8'($urandom));
      end else begin
        repeat ($urandom_range(4, 1)) begin
          push_event(i2cpm_pkg::opcode_e'($urandom_range(3)), 8'($urandom));
        end
      end
    end
  endtask

  task automatic queue_directed();
    // transmit and address byte with no match right after reset
    push_event(i2cpm_pkg::OP_BYTE_TX, 8'h00);
    push_event(i2cpm_pkg::OP_BYTE_RX, 8'h7E);
    push_event(i2cpm_pkg::OP_BYTE_RX, 8'hA5);
    // select page seventy_f by writing across the page boundary
    push_event(i2cpm_pkg::OP_BYTE_RX, i2cpm_pkg::SelSeventyF);
    push_event(i2cpm_pkg::OP_BYTE_RX, TopAddr);
    // write across the top of the map back into the lower page
    push_event(i2cpm_pkg::OP_ADDR_WR, 8'h00);
    push_event(i2cpm_pkg::OP_BYTE_RX, 8'hFE);
    push_event(i2cpm_pkg::OP_BYTE_RX, 8'h11);
    push_event(i2cpm_pkg::OP_BYTE_RX, 8'h22);
    push_event(i2cpm_pkg::OP_BYTE_RX, 8'h33);
    // invalid page select gets rewritten to zero on crossing
    push_event(i2cpm_pkg::OP_ADDR_WR, 8'hFF);
    push_event(i2cpm_pkg::OP_BYTE_RX, SelectAddr);
    push_event(i2cpm_pkg::OP_BYTE_RX, 8'h5A);
    push_event(i2cpm_pkg::OP_BYTE_RX, 8'hC3);
    // read back across both page boundaries
    push_event(i2cpm_pkg::OP_ADDR_WR, 8'h00);
    push_event(i2cpm_pkg::OP_BYTE_RX, 8'h7D);
    push_event(i2cpm_pkg::OP_ADDR_RD, 8'hFF);
    repeat (4) push_event(i2cpm_pkg::OP_BYTE_TX, 8'h00);
    push_event(i2cpm_pkg::OP_ADDR_WR, 8'h00);
    push_event(i2cpm_pkg::OP_BYTE_RX, TopAddr);
    push_event(i2cpm_pkg::OP_ADDR_RD, 8'h00);
    repeat (2) push_event(i2cpm_pkg::OP_BYTE_TX, 8'hFF);
  endtask

  initial begin
    int unsigned idle_tab [NumPhases];
    int unsigned stall_tab [NumPhases];
    idle_tab  = '{0, 71, 0, 16};
    stall_tab = '{0, 0, 71, 16};
    for (int b = 0; b < 3; b++) begin
      for (int r = 0; r < i2cpm_pkg::PageBytes; r++) page_mem[b][r] = 8'h00;
    end
    cur_addr = 8'h00;
    cur_bank = i2cpm_pkg::BANK_LOWER;
    want_addr_byte = 1'b1;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      send_idle_pct = idle_tab[p];
      stall_pct = stall_tab[p];
      if (p == 0) queue_directed();
      queue_random(RandomItems / NumPhases);
      while (pending_events.size() != 0) @(posedge clk_i);
    end

    while (drv_valid || tx_expected.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Covered %0d bus events under four pressure settings; %0d tx bytes compared.",
             events_accepted, bytes_checked);
    $display("Page select, boundary crossings and wrap exercised; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && tx_expected.size() == 0) begin
      $display("i2c_target_paged_memory_map verification clean");
    end else begin
      $display("i2c_target_paged_memory_map verification failed");
    end
    $finish;
  end

endmodule
